// ===== rtl/bsrr_pkg.sv =====
// Shared types, codes and constants of the ball smoothed radius regressor.
`timescale 1ns / 1ps
`default_nettype none

package bsrr_pkg;

	// Default sizes of the training store.
	localparam int MAX_POINTS_DEF = 256;
	localparam int DIMENSIONS_DEF = 4;

	// Fixed field widths.
	localparam int COORD_W   = 16;
	localparam int RAD_W     = 17;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int CNT_OUT_W = 9;
	localparam int CFG_IDX_W = 2;

	// Distance and weight arithmetic widths.
	localparam int SQ_W    = 32;           // one squared coordinate difference
	localparam int S_W     = 34;           // sum of squared differences
	localparam int ROOT_W  = 25;           // floor(sqrt(S * 2^16))
	localparam int SQ_IN_W = 2 * ROOT_W;   // radicand width
	localparam int WGT_W   = 17;           // weight 1/(d+1), 16 fraction bits
	localparam int WDIV_W  = 26;           // weight divisor dq + 1.0
	localparam int PROD_W  = 34;           // smoothed value times weight

	localparam logic [32:0]       ONE_Q32 = 33'h1_0000_0000;
	localparam logic [WDIV_W-1:0] ONE_Q16 = 26'h001_0000;

	// Saturation bounds of a Q8.8 result.
	localparam int SAT_POS     = 32767;
	localparam int SAT_NEG_MAG = 32768;
	localparam logic signed [COORD_W-1:0] EST_MAX = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] EST_MIN = 16'sh8000;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEST   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_LOADED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SMOOTHED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CLASSIFIED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE       = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_READY  = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RTRAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RTEST    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                take;
		logic                load_wr;
		logic                r2;
		logic                smooth;
		logic                clr_i;
		logic                rd_i;
		logic                ld_i;
		logic                clr_acc;
		logic                rd_j;
		logic                sq;
		logic                sum;
		logic                acc_plain;
		logic                next_j;
		logic                sqrt_start;
		logic                div_start;
		logic                div_w;
		logic                mul;
		logic                acc_w;
		logic                row_wr;
		logic                set_ready;
		logic                res_wr;
		logic [STATUS_W-1:0] code;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              ready;
		logic              i_end;
		logic              j_end;
		logic              hit;
		logic              weighted;
		logic              sqrt_done;
		logic              div_done;
		logic              ncnt_zero;
		logic              out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/ball_smoothed_radius_regressor_core.sv =====
// A load stores the point and returns a result. A classify scans every stored point (read,
// square, sum, accumulate), then, when it has neighbours, divides for the mean with the divider
// of width DDW (44 at 256 entries). Weighted mode adds a root and a weight divide per neighbour.
// A finish runs one such scan for each stored point. One item is in work at a time; the next
// is taken once the result sits in the output register.
// Reset clears configuration, the point count and the smoothed flag; stores are undefined.
`timescale 1ns / 1ps
`default_nettype none

module ball_smoothed_radius_regressor_core #(
	parameter int MAX_POINTS = bsrr_pkg::MAX_POINTS_DEF,
	parameter int DIMENSIONS = bsrr_pkg::DIMENSIONS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire [bsrr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [bsrr_pkg::RAD_W-1:0]              cfg_data,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire [bsrr_pkg::MODE_W-1:0]             mode,
	input  wire signed [bsrr_pkg::COORD_W-1:0]     coord_0,
	input  wire signed [bsrr_pkg::COORD_W-1:0]     coord_1,
	input  wire signed [bsrr_pkg::COORD_W-1:0]     coord_2,
	input  wire signed [bsrr_pkg::COORD_W-1:0]     coord_3,
	input  wire signed [bsrr_pkg::COORD_W-1:0]     target_value,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic [bsrr_pkg::STATUS_W-1:0]          status,
	output logic signed [bsrr_pkg::COORD_W-1:0]    estimate,
	output logic [bsrr_pkg::CNT_OUT_W-1:0]         neighbour_count,
	output logic [bsrr_pkg::CNT_OUT_W-1:0]         training_count
);
	import bsrr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Configuration registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	bsrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	bsrr_dp #(.MAX_POINTS(MAX_POINTS), .DIMENSIONS(DIMENSIONS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (mode),
		.coord_0         (coord_0),
		.coord_1         (coord_1),
		.coord_2         (coord_2),
		.coord_3         (coord_3),
		.target_value    (target_value),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.status          (status),
		.estimate        (estimate),
		.neighbour_count (neighbour_count),
		.training_count  (training_count)
	);

`ifndef SYNTHESIS
	// An estimate is only given with a classified item.
	a_est_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_CLASSIFIED) |-> (estimate == '0))
		else $error("estimate nonzero without a classification");

	// Neighbour counts appear only for test items that ran a scan.
	a_ncnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_CLASSIFIED) && (status != ST_NONE)
		|-> (neighbour_count == '0))
		else $error("neighbour count reported for a non-test result");

	// A classified item has at least one neighbour.
	a_class_ncnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_CLASSIFIED) |-> (neighbour_count != '0))
		else $error("classified without neighbours");

	// Items are worked one at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");
`endif

endmodule

`default_nettype wire

// ===== rtl/bsrr_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module bsrr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire                                           clk,
	input  wire                                           we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   addr,
	input  wire [WIDTH-1:0]                               wdata,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/bsrr_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bsrr_sqrt (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire [bsrr_pkg::SQ_IN_W-1:0]        radicand,
	output logic [bsrr_pkg::ROOT_W-1:0]        root,
	output logic                               done
);
	import bsrr_pkg::*;

	localparam int CNTW = $clog2(ROOT_W + 1);

	logic [SQ_IN_W-1:0] x_q;
	logic [ROOT_W:0]    rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNTW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [ROOT_W+2:0]  rem_sh;
	logic [ROOT_W+2:0]  trial;
	logic               take_bit;

	// One digit of the root per step.
	always_comb begin
		rem_sh   = {rem_q, x_q[SQ_IN_W-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
		take_bit = (rem_sh >= trial);
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Remainder and root registers.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[SQ_IN_W-3:0], 2'b00};
			if (take_bit) begin
				rem_q  <= (ROOT_W + 1)'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== rtl/bsrr_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bsrr_div #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 27
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [NUM_W-1:0]  dividend,
	input  wire [DEN_W-1:0]  divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);

	localparam int CNTW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	// Trial subtraction of the divisor.
	always_comb begin
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		fits   = (rem_sh >= {1'b0, dvs_q});
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DEN_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== rtl/bsrr_dp.sv =====
// Datapath: configuration, training stores, distance, accumulators and result register.
`timescale 1ns / 1ps
`default_nettype none

module bsrr_dp #(
	parameter int MAX_POINTS = bsrr_pkg::MAX_POINTS_DEF,
	parameter int DIMENSIONS = bsrr_pkg::DIMENSIONS_DEF
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  bsrr_pkg::cmd_t                            cmd,
	output bsrr_pkg::sts_t                            sts,
	input  wire                                       cfg_valid,
	input  wire [bsrr_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  wire [bsrr_pkg::RAD_W-1:0]                 cfg_data,
	input  wire [bsrr_pkg::MODE_W-1:0]                mode,
	input  wire signed [bsrr_pkg::COORD_W-1:0]        coord_0,
	input  wire signed [bsrr_pkg::COORD_W-1:0]        coord_1,
	input  wire signed [bsrr_pkg::COORD_W-1:0]        coord_2,
	input  wire signed [bsrr_pkg::COORD_W-1:0]        coord_3,
	input  wire signed [bsrr_pkg::COORD_W-1:0]        target_value,
	input  wire                                       out_ready,
	output logic                                      out_valid,
	output logic [bsrr_pkg::STATUS_W-1:0]             status,
	output logic signed [bsrr_pkg::COORD_W-1:0]       estimate,
	output logic [bsrr_pkg::CNT_OUT_W-1:0]            neighbour_count,
	output logic [bsrr_pkg::CNT_OUT_W-1:0]            training_count
);
	import bsrr_pkg::*;

	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CRW = DIMENSIONS * COORD_W;
	localparam int NW  = PROD_W + CW;
	localparam int DW  = WGT_W + CW;
	localparam int DDW = NW + 1;
	localparam int DVW = (DW + 1 > WDIV_W) ? DW + 1 : WDIV_W;

	// Configuration registers.
	logic             weighted_q;
	logic [RAD_W-1:0] rtrain_q;
	logic [RAD_W-1:0] rtest_q;

	// Item and scan state.
	logic [MODE_W-1:0]         mode_q;
	logic signed [COORD_W-1:0] pt_q [DIMENSIONS];
	logic signed [COORD_W-1:0] tgt_q;
	logic [CW-1:0]             count_q;
	logic                      ready_q;
	logic [CW-1:0]             i_q;
	logic [CW-1:0]             j_q;
	logic [S_W-1:0]            r2_q;
	logic [SQ_W-1:0]           sq_q [DIMENSIONS];
	logic signed [COORD_W-1:0] val_q;
	logic [S_W-1:0]            s_q;
	logic signed [NW-1:0]      num_q;
	logic [DW-1:0]             den_q;
	logic [CW-1:0]             ncnt_q;
	logic signed [PROD_W-1:0]  prod_q;

	// Result register.
	logic                         out_valid_q;
	logic [STATUS_W-1:0]          status_q;
	logic signed [COORD_W-1:0]    estimate_q;
	logic [CNT_OUT_W-1:0]         ncount_out_q;
	logic [CNT_OUT_W-1:0]         tcount_out_q;

	// Combinational helpers.
	logic signed [COORD_W-1:0] coord_in [4];
	logic [CRW-1:0]            crd_wdata;
	logic [CRW-1:0]            crd_rdata;
	logic [AW-1:0]             crd_addr;
	logic [COORD_W-1:0]        tgt_rdata;
	logic [COORD_W-1:0]        smo_rdata;
	logic [AW-1:0]             tgt_addr;
	logic [AW-1:0]             smo_addr;
	logic signed [COORD_W:0]   diff [DIMENSIONS];
	logic signed [2*COORD_W+1:0] dsq [DIMENSIONS];
	logic [S_W-1:0]            sum_c;
	logic [RAD_W-1:0]          rsel;
	logic [ROOT_W-1:0]         root;
	logic                      sqrt_done;
	logic [DDW-1:0]            quo;
	logic                      div_done;
	logic [DDW-1:0]            div_num;
	logic [DVW-1:0]            div_den;
	logic [NW-1:0]             mag;
	logic [WGT_W-1:0]          wgt;
	logic signed [COORD_W-1:0] rnd;
	logic                      ncnt_zero;

	assign coord_in[0] = coord_0;
	assign coord_in[1] = coord_1;
	assign coord_in[2] = coord_2;
	assign coord_in[3] = coord_3;

	// Training stores.
	always_comb begin
		for (int k = 0; k < DIMENSIONS; k++) begin
			crd_wdata[k*COORD_W +: COORD_W] = pt_q[k];
		end
	end

	assign crd_addr = cmd.load_wr ? count_q[AW-1:0] : (cmd.rd_i ? i_q[AW-1:0] : j_q[AW-1:0]);
	assign tgt_addr = cmd.load_wr ? count_q[AW-1:0] : j_q[AW-1:0];
	assign smo_addr = cmd.row_wr ? i_q[AW-1:0] : j_q[AW-1:0];

	bsrr_ram #(.WIDTH(CRW), .DEPTH(MAX_POINTS)) u_crd_ram (
		.clk   (clk),
		.we    (cmd.load_wr),
		.addr  (crd_addr),
		.wdata (crd_wdata),
		.rdata (crd_rdata)
	);

	bsrr_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_tgt_ram (
		.clk   (clk),
		.we    (cmd.load_wr),
		.addr  (tgt_addr),
		.wdata (tgt_q),
		.rdata (tgt_rdata)
	);

	bsrr_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_smo_ram (
		.clk   (clk),
		.we    (cmd.row_wr),
		.addr  (smo_addr),
		.wdata (rnd),
		.rdata (smo_rdata)
	);

	// Per-axis differences and squares against the stored point.
	always_comb begin
		for (int k = 0; k < DIMENSIONS; k++) begin
			diff[k] = {pt_q[k][COORD_W-1], pt_q[k]}
				- {crd_rdata[k*COORD_W+COORD_W-1], crd_rdata[k*COORD_W +: COORD_W]};
			dsq[k]  = diff[k] * diff[k];
		end
	end

	// Sum of squares.
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < DIMENSIONS; k++) begin
			sum_c = sum_c + S_W'(sq_q[k]);
		end
	end

	assign rsel = cmd.smooth ? rtrain_q : rtest_q;

	// Square root of the distance and the shared divider.
	bsrr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand ({s_q, 16'h0000}),
		.root     (root),
		.done     (sqrt_done)
	);

	always_comb begin
		mag = num_q[NW-1] ? unsigned'(-num_q) : unsigned'(num_q);
		if (cmd.div_w) begin
			div_num = DDW'(ONE_Q32);
			div_den = DVW'({1'b0, root} + ONE_Q16);
		end else begin
			div_num = {mag, 1'b0} + DDW'(den_q);
			div_den = DVW'({den_q, 1'b0});
		end
	end

	bsrr_div #(.NUM_W(DDW), .DEN_W(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (quo),
		.done     (div_done)
	);

	assign wgt       = quo[WGT_W-1:0];
	assign ncnt_zero = (ncnt_q == '0);

	// Rounded mean, saturated to Q8.8.
	always_comb begin
		if (ncnt_zero) begin
			rnd = '0;
		end else if (num_q[NW-1]) begin
			rnd = (quo > DDW'(SAT_NEG_MAG)) ? EST_MIN : COORD_W'(~quo + DDW'(1));
		end else begin
			rnd = (quo > DDW'(SAT_POS)) ? EST_MAX : COORD_W'(quo);
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q  <= 1'b0;
			rtrain_q    <= '0;
			rtest_q     <= '0;
			count_q     <= '0;
			ready_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WEIGHTED: weighted_q <= cfg_data[0];
					CFG_RTRAIN:   rtrain_q   <= cfg_data;
					CFG_RTEST:    rtest_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_wr) begin
				count_q <= count_q + CW'(1);
				ready_q <= 1'b0;
			end
			if (cmd.set_ready) begin
				ready_q <= 1'b1;
			end
			if (cmd.clr_i) begin
				i_q <= '0;
			end else if (cmd.row_wr) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.clr_acc) begin
				j_q <= '0;
			end else if (cmd.next_j) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.res_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, scan registers and accumulators.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= mode;
			tgt_q  <= target_value;
			for (int k = 0; k < DIMENSIONS; k++) begin
				pt_q[k] <= coord_in[k];
			end
		end else if (cmd.ld_i) begin
			for (int k = 0; k < DIMENSIONS; k++) begin
				pt_q[k] <= crd_rdata[k*COORD_W +: COORD_W];
			end
		end
		if (cmd.r2) begin
			r2_q <= rsel * rsel;
		end
		if (cmd.sq) begin
			for (int k = 0; k < DIMENSIONS; k++) begin
				sq_q[k] <= dsq[k][SQ_W-1:0];
			end
			val_q <= cmd.smooth ? tgt_rdata : smo_rdata;
		end
		if (cmd.sum) begin
			s_q <= sum_c;
		end
		if (cmd.mul) begin
			prod_q <= val_q * signed'({1'b0, wgt});
		end
		if (cmd.clr_acc) begin
			num_q  <= '0;
			den_q  <= '0;
			ncnt_q <= '0;
		end else if (cmd.acc_plain) begin
			num_q  <= num_q + NW'(val_q);
			den_q  <= den_q + DW'(1);
			ncnt_q <= ncnt_q + CW'(1);
		end else if (cmd.acc_w) begin
			num_q  <= num_q + NW'(prod_q);
			den_q  <= den_q + DW'(wgt);
			ncnt_q <= ncnt_q + CW'(1);
		end
		if (cmd.res_wr) begin
			status_q     <= cmd.code;
			estimate_q   <= (cmd.code == ST_CLASSIFIED) ? rnd : '0;
			ncount_out_q <= (cmd.code == ST_CLASSIFIED || cmd.code == ST_NONE)
				? CNT_OUT_W'(ncnt_q) : '0;
			tcount_out_q <= CNT_OUT_W'(count_q);
		end
	end

	// Status to the controller.
	always_comb begin
		sts.mode      = mode_q;
		sts.full      = (count_q == CW'(MAX_POINTS));
		sts.ready     = ready_q;
		sts.i_end     = (i_q == count_q);
		sts.j_end     = (j_q == count_q);
		sts.hit       = (s_q <= r2_q);
		sts.weighted  = weighted_q;
		sts.sqrt_done = sqrt_done;
		sts.div_done  = div_done;
		sts.ncnt_zero = ncnt_zero;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign estimate        = estimate_q;
	assign neighbour_count = ncount_out_q;
	assign training_count  = tcount_out_q;

endmodule

`default_nettype wire

// ===== rtl/bsrr_ctrl.sv =====
// Controller state machine: sequences loads, smoothing passes and test scans.
`timescale 1ns / 1ps
`default_nettype none

module bsrr_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	output bsrr_pkg::cmd_t  cmd,
	input  bsrr_pkg::sts_t  sts
);
	import bsrr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_LOAD, S_R2, S_ROW_CHK, S_ROW_RD, S_ROW_LD,
		S_CHK_J, S_RD, S_SQ, S_SUM, S_ACC, S_SQRT_GO, S_SQRT_W,
		S_DIVW_GO, S_DIVW_W, S_MUL, S_ACCW, S_DIVR_GO, S_DIVR_W,
		S_ROW_WR, S_RES
	} state_t;

	state_t              state_q, state_d;
	logic                smooth_q, smooth_d;
	logic [STATUS_W-1:0] code_q, code_d;

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		smooth_d   = smooth_q;
		code_d     = code_q;
		cmd        = '0;
		cmd.smooth = smooth_q;
		cmd.code   = code_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.mode)
					MODE_LOAD: begin
						if (sts.full) begin
							code_d  = ST_FULL;
							state_d = S_RES;
						end else begin
							state_d = S_LOAD;
						end
					end
					MODE_FINISH: begin
						smooth_d = 1'b1;
						state_d  = S_R2;
					end
					MODE_TEST: begin
						if (!sts.ready) begin
							code_d  = ST_NOT_READY;
							state_d = S_RES;
						end else begin
							smooth_d = 1'b0;
							state_d  = S_R2;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_LOAD: begin
				cmd.load_wr = 1'b1;
				code_d      = ST_LOADED;
				state_d     = S_RES;
			end
			S_R2: begin
				cmd.r2      = 1'b1;
				cmd.clr_i   = 1'b1;
				cmd.clr_acc = 1'b1;
				state_d     = smooth_q ? S_ROW_CHK : S_CHK_J;
			end
			S_ROW_CHK: begin
				if (sts.i_end) begin
					cmd.set_ready = 1'b1;
					code_d        = ST_SMOOTHED;
					state_d       = S_RES;
				end else begin
					state_d = S_ROW_RD;
				end
			end
			S_ROW_RD: begin
				cmd.rd_i = 1'b1;
				state_d  = S_ROW_LD;
			end
			S_ROW_LD: begin
				cmd.ld_i    = 1'b1;
				cmd.clr_acc = 1'b1;
				state_d     = S_CHK_J;
			end
			S_CHK_J: begin
				if (!sts.j_end) begin
					state_d = S_RD;
				end else if (!sts.ncnt_zero) begin
					state_d = S_DIVR_GO;
				end else if (smooth_q) begin
					state_d = S_ROW_WR;
				end else begin
					code_d  = ST_NONE;
					state_d = S_RES;
				end
			end
			S_RD: begin
				cmd.rd_j = 1'b1;
				state_d  = S_SQ;
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				if (sts.hit && sts.weighted && !smooth_q) begin
					state_d = S_SQRT_GO;
				end else begin
					cmd.acc_plain = sts.hit;
					cmd.next_j    = 1'b1;
					state_d       = S_CHK_J;
				end
			end
			S_SQRT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = S_SQRT_W;
			end
			S_SQRT_W: begin
				if (sts.sqrt_done) begin
					state_d = S_DIVW_GO;
				end
			end
			S_DIVW_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_w     = 1'b1;
				state_d       = S_DIVW_W;
			end
			S_DIVW_W: begin
				if (sts.div_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACCW;
			end
			S_ACCW: begin
				cmd.acc_w  = 1'b1;
				cmd.next_j = 1'b1;
				state_d    = S_CHK_J;
			end
			S_DIVR_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVR_W;
			end
			S_DIVR_W: begin
				if (sts.div_done) begin
					if (smooth_q) begin
						state_d = S_ROW_WR;
					end else begin
						code_d  = ST_CLASSIFIED;
						state_d = S_RES;
					end
				end
			end
			S_ROW_WR: begin
				cmd.row_wr = 1'b1;
				state_d    = S_ROW_CHK;
			end
			S_RES: begin
				cmd.res_wr = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			smooth_q <= 1'b0;
			code_q   <= ST_LOADED;
		end else begin
			state_q  <= state_d;
			smooth_q <= smooth_d;
			code_q   <= code_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

`default_nettype wire
